/* rtl/dtq_pkg.sv */
// Shared types and constants for the drop-tail queue with saturation feedback.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

    // Default geometry
    localparam int unsigned DEF_DEPTH    = 256;
    localparam int unsigned DEF_TAG_BITS = 16;

    // Configuration port
    localparam int unsigned CFG_W     = 9;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_QUEUE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SAT_LEVEL   = 1'b1;
    localparam logic [CFG_W-1:0] RST_QUEUE_LIMIT = 9'd256;
    localparam logic [CFG_W-1:0] RST_SAT_LEVEL   = 9'd192;

    // Reported length width
    localparam int unsigned LEN_W = 9;

    // Event codes
    localparam logic ACT_ARRIVAL = 1'b0;
    localparam logic ACT_DONE    = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] queue_limit;
        logic [CFG_W-1:0] saturation_level;
    } t_cfg;

    // Result fields apart from the tag, whose width is a parameter
    typedef struct packed {
        logic             sent_valid;
        logic             sent_is_feedback;
        logic             sent_feedback_value;
        logic             dropped;
        logic [LEN_W-1:0] queue_length;
        logic             busy_res;
    } t_res_flags;

endpackage

`default_nettype wire

/* rtl/dtq_ifs.sv */
// Valid/ready channel interfaces: event input and result output.
// Depends on dtq_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

interface dtq_in_if #(
    parameter int unsigned TAG_BITS = dtq_pkg::DEF_TAG_BITS
);
    logic                valid;
    logic                ready;
    logic                action;
    logic [TAG_BITS-1:0] packet_tag;

    modport source (output valid, action, packet_tag, input ready);
    modport sink   (input valid, action, packet_tag, output ready);
endinterface

interface dtq_out_if #(
    parameter int unsigned TAG_BITS = dtq_pkg::DEF_TAG_BITS
);
    logic                      valid;
    logic                      ready;
    logic                      sent_valid;
    logic [TAG_BITS-1:0]       sent_tag;
    logic                      sent_is_feedback;
    logic                      sent_feedback_value;
    logic                      dropped;
    logic [dtq_pkg::LEN_W-1:0] queue_length;
    logic                      busy_res;

    modport source (output valid, sent_valid, sent_tag, sent_is_feedback,
                    sent_feedback_value, dropped, queue_length, busy_res,
                    input ready);
    modport sink   (input valid, sent_valid, sent_tag, sent_is_feedback,
                    sent_feedback_value, dropped, queue_length, busy_res,
                    output ready);
endinterface

`default_nettype wire

/* rtl/drop_tail_queue_with_saturation_feedback.sv */
// Drop-tail packet queue with saturation feedback: top level.
// An input transfer reaches its result through the input register and then the result register.
// Throughput: 1 event per cycle while the result channel is not stalled; the head entry sits
// in a register and the entry behind it is prefetched from the one-write one-read entry memory.
// Reset (synchronous, active low): queue empty, server idle, not saturated, limit 256,
// saturation level 192. The entry memory is not cleared; only held entries are ever used.
`timescale 1ns / 1ps
`default_nettype none

module drop_tail_queue_with_saturation_feedback #(
    parameter int unsigned DEPTH    = dtq_pkg::DEF_DEPTH,
    parameter int unsigned TAG_BITS = dtq_pkg::DEF_TAG_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    dtq_in_if.sink                             i_pkt,
    dtq_out_if.source                          o_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [dtq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [dtq_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int unsigned EW = TAG_BITS + 2;
    localparam int unsigned IW = $clog2(DEPTH);

    // Input register: holds one event until it can advance into the result register
    logic                r_in_vld;
    logic                n_in_vld;
    logic                r_in_act;
    logic [TAG_BITS-1:0] r_in_tag;

    // Result register
    logic                r_out_vld;
    logic                n_out_vld;
    dtq_pkg::t_res_flags r_out;
    logic [TAG_BITS-1:0] r_out_tag;

    logic                in_xfer;
    logic                fire;

    dtq_pkg::t_cfg       cfg;
    dtq_pkg::t_res_flags step_res;
    logic [TAG_BITS-1:0] step_tag;

    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic [IW-1:0]       rd_addr;
    logic [EW-1:0]       rd_data;

    // Advance the held event when the result register is free or drains this cycle
    assign fire        = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_pkt.ready = !r_in_vld || fire;
    assign in_xfer     = i_pkt.valid && i_pkt.ready;

    always_comb begin
        n_in_vld = r_in_vld;
        if (in_xfer) begin
            n_in_vld = 1'b1;
        end else if (fire) begin
            n_in_vld = 1'b0;
        end

        n_out_vld = r_out_vld;
        if (fire) begin
            n_out_vld = 1'b1;
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_act <= i_pkt.action;
            r_in_tag <= i_pkt.packet_tag;
        end
        if (fire) begin
            r_out     <= step_res;
            r_out_tag <= step_tag;
        end
    end

    dtq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    dtq_store #(
        .DEPTH (DEPTH),
        .EW    (EW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    dtq_step #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_action   (r_in_act),
        .i_tag      (r_in_tag),
        .i_cfg      (cfg),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_addr  (rd_addr),
        .o_res      (step_res),
        .o_sent_tag (step_tag)
    );

    // Drive the result channel straight from the result register
    assign o_res.valid               = r_out_vld;
    assign o_res.sent_valid          = r_out.sent_valid;
    assign o_res.sent_tag            = r_out_tag;
    assign o_res.sent_is_feedback    = r_out.sent_is_feedback;
    assign o_res.sent_feedback_value = r_out.sent_feedback_value;
    assign o_res.dropped             = r_out.dropped;
    assign o_res.queue_length        = r_out.queue_length;
    assign o_res.busy_res            = r_out.busy_res;

endmodule

`default_nettype wire

/* rtl/dtq_cfg.sv */
// Configuration registers: queue limit and saturation level.
// Depends on dtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtq_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dtq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [dtq_pkg::CFG_W-1:0]     i_cfg_data,
    output dtq_pkg::t_cfg                      o_cfg
);

    dtq_pkg::t_cfg r_cfg;
    dtq_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                dtq_pkg::CFG_IDX_QUEUE_LIMIT: n_cfg.queue_limit      = i_cfg_data;
                dtq_pkg::CFG_IDX_SAT_LEVEL:   n_cfg.saturation_level = i_cfg_data;
                default:                      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.queue_limit      <= dtq_pkg::RST_QUEUE_LIMIT;
            r_cfg.saturation_level <= dtq_pkg::RST_SAT_LEVEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/dtq_store.sv */
// Entry memory: one write port, one registered read port with write bypass.
// Depends on dtq_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module dtq_store #(
    parameter  int unsigned DEPTH = dtq_pkg::DEF_DEPTH,
    parameter  int unsigned EW    = dtq_pkg::DEF_TAG_BITS + 2,
    localparam int unsigned IW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [IW-1:0] i_wr_addr,
    input  wire logic [EW-1:0] i_wr_data,
    input  wire logic [IW-1:0] i_rd_addr,
    output logic      [EW-1:0] o_rd_data
);

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Forward a same-cycle write to the read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/dtq_step.sv */
// Queue state and the per-event update: drop, append, serve, feedback push.
// Depends on dtq_pkg; drives the write and read-ahead ports of dtq_store.
`timescale 1ns / 1ps
`default_nettype none

module dtq_step #(
    parameter  int unsigned DEPTH    = dtq_pkg::DEF_DEPTH,
    parameter  int unsigned TAG_BITS = dtq_pkg::DEF_TAG_BITS,
    localparam int unsigned EW       = TAG_BITS + 2,
    localparam int unsigned IW       = $clog2(DEPTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire logic                i_action,
    input  wire logic [TAG_BITS-1:0] i_tag,
    input  wire dtq_pkg::t_cfg       i_cfg,
    input  wire logic [EW-1:0]       i_rd_data,
    output logic                     o_wr_en,
    output logic      [IW-1:0]       o_wr_addr,
    output logic      [EW-1:0]       o_wr_data,
    output logic      [IW-1:0]       o_rd_addr,
    output dtq_pkg::t_res_flags      o_res,
    output logic      [TAG_BITS-1:0] o_sent_tag
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam int unsigned CMP_W = (CNT_W > dtq_pkg::CFG_W) ? CNT_W : dtq_pkg::CFG_W;
    localparam int unsigned FB_POS  = TAG_BITS;
    localparam int unsigned VAL_POS = TAG_BITS + 1;

    function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] idx);
        logic [IW-1:0] res;
        if (idx == IW'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + IW'(1);
        end
        return res;
    endfunction

    logic [IW-1:0]    r_head;
    logic [IW-1:0]    n_head;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_sat;
    logic             n_sat;
    logic             r_busy;
    logic             n_busy;
    logic [EW-1:0]    r_hd;      // entry at the head; memory copy may be stale
    logic [EW-1:0]    n_hd;

    logic             cnt_zero;
    logic             cnt_one;
    logic             full;
    logic             do_app;
    logic             do_drop;
    logic             do_serve;
    logic             sat;
    logic             push;
    logic [CNT_W-1:0] cnt_app;
    logic [CNT_W-1:0] cnt_pop;
    logic [SUM_W-1:0] tail_sum;
    logic [IW-1:0]    tail;
    logic [IW-1:0]    head_inc;
    logic [EW-1:0]    tag_ent;
    logic [EW-1:0]    fb_ent;
    logic [EW-1:0]    pop_ent;
    logic [CMP_W-1:0] len_ext;

    always_comb begin
        cnt_zero = (r_count == '0);
        cnt_one  = (r_count == CNT_W'(1));
        full     = (CMP_W'(r_count) >= CMP_W'(i_cfg.queue_limit))
                || (r_count == CNT_W'(DEPTH));
        do_app   = (i_action == dtq_pkg::ACT_ARRIVAL) && !full;
        do_drop  = (i_action == dtq_pkg::ACT_ARRIVAL) && full;
        do_serve = (do_app && !r_busy)
                || ((i_action == dtq_pkg::ACT_DONE) && !cnt_zero);

        tag_ent  = {2'b00, i_tag};
        // An empty queue with an idle server serves the arriving packet straight away
        pop_ent  = cnt_zero ? tag_ent : r_hd;

        cnt_app  = r_count + CNT_W'(do_app);
        cnt_pop  = cnt_app - CNT_W'(do_serve);
        sat      = CMP_W'(cnt_pop) > CMP_W'(i_cfg.saturation_level);
        push     = do_serve && (sat != r_sat);
        fb_ent   = {sat, 1'b1, TAG_BITS'(0)};

        tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (tail_sum >= SUM_W'(DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(DEPTH);
        end
        tail     = tail_sum[IW-1:0];
        head_inc = slot_inc(r_head);
    end

    // Next state: pop then push at the front leaves the head index in place
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_sat   = r_sat;
        n_busy  = r_busy;
        n_hd    = r_hd;
        if (i_fire) begin
            n_count = cnt_pop + CNT_W'(push);
            if (do_serve && !push) begin
                n_head = head_inc;
            end
            if (do_serve) begin
                n_sat  = sat;
                n_busy = 1'b1;
            end else if (i_action == dtq_pkg::ACT_DONE) begin
                n_busy = 1'b0;
            end
            if (push) begin
                n_hd = fb_ent;
            end else if (do_serve) begin
                // Second entry: just appended, or prefetched from memory
                n_hd = cnt_one ? tag_ent : i_rd_data;
            end else if (do_app && cnt_zero) begin
                n_hd = tag_ent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_sat   <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_sat   <= n_sat;
            r_busy  <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hd <= n_hd;
    end

    assign o_wr_en   = i_fire && do_app;
    assign o_wr_addr = tail;
    assign o_wr_data = tag_ent;
    // Keep the entry behind the head prefetched for the next event
    assign o_rd_addr = slot_inc(n_head);

    always_comb begin
        len_ext                   = CMP_W'(n_count);
        o_res.sent_valid          = do_serve;
        o_res.sent_is_feedback    = do_serve && pop_ent[FB_POS];
        o_res.sent_feedback_value = do_serve && pop_ent[FB_POS] && pop_ent[VAL_POS];
        o_res.dropped             = do_drop;
        o_res.queue_length        = len_ext[dtq_pkg::LEN_W-1:0];
        o_res.busy_res            = n_busy;
        o_sent_tag                = (do_serve && !pop_ent[FB_POS])
                                  ? pop_ent[TAG_BITS-1:0] : '0;
    end

endmodule

`default_nettype wire

/* rtl/dtq_checker.sv */
// Port-level checks on the result channel of the drop-tail queue, bound to the top level.
// Depends on dtq_pkg and drop_tail_queue_with_saturation_feedback.
`timescale 1ns / 1ps
`default_nettype none

module dtq_checker #(
    parameter int unsigned TAG_BITS = dtq_pkg::DEF_TAG_BITS
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_out_valid,
    input wire logic                      i_sent_valid,
    input wire logic [TAG_BITS-1:0]       i_sent_tag,
    input wire logic                      i_sent_is_feedback,
    input wire logic                      i_sent_feedback_value,
    input wire logic                      i_dropped,
    input wire logic [dtq_pkg::LEN_W-1:0] i_queue_length,
    input wire logic                      i_busy_res
);

    // No result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A feedback entry carries no tag and only goes out as a sent entry
    a_fb_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_sent_is_feedback || i_sent_feedback_value))
            |-> (i_sent_valid && i_sent_is_feedback && (i_sent_tag == '0)))
        else $error("malformed feedback result");

    // A dropped arrival is never served
    a_drop_nosend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_dropped) |-> !i_sent_valid)
        else $error("dropped arrival was also sent");

    // An idle server implies an empty queue and nothing sent
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_busy_res) |-> (!i_sent_valid && (i_queue_length == '0)))
        else $error("server idle with entries held or sent");

endmodule

bind drop_tail_queue_with_saturation_feedback dtq_checker #(
    .TAG_BITS (TAG_BITS)
) u_dtq_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_out_valid           (o_res.valid),
    .i_sent_valid          (o_res.sent_valid),
    .i_sent_tag            (o_res.sent_tag),
    .i_sent_is_feedback    (o_res.sent_is_feedback),
    .i_sent_feedback_value (o_res.sent_feedback_value),
    .i_dropped             (o_res.dropped),
    .i_queue_length        (o_res.queue_length),
    .i_busy_res            (o_res.busy_res)
);

`default_nettype wire
